FILE: design/assert_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define BLCS_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("blcs assertion failed");

// Property checked at every rising edge, reset included.
`define BLCS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("blcs assertion failed during or after reset");

`endif

FILE: design/blcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blcs_pkg;

  // Fixed geometry of the core cluster.
  localparam int unsigned CoreCount         = 8;
  localparam int unsigned CoreIdxW          = 3;
  localparam int unsigned LoadW             = 8;
  localparam int unsigned UtilW             = 11;
  localparam int unsigned CfgDataW          = 11;
  localparam int unsigned SmallCoresDefault = 4;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_BLOCK_ENABLE     = 3'd0,
    REG_HEAVY_THRESHOLD  = 3'd1,
    REG_LIGHT_THRESHOLD  = 3'd2,
    REG_RESERVE_ENABLE   = 3'd3,
    REG_RESERVED_CORE    = 3'd4,
    REG_SATURATION_LEVEL = 3'd5,
    REG_PACKING_ON       = 3'd6,
    REG_PACK_LIMIT       = 3'd7
  } reg_idx_e;

  // Register reset values.
  localparam logic [UtilW-1:0]    HeavyThresholdRst  = 11'd700;
  localparam logic [UtilW-1:0]    LightThresholdRst  = 11'd256;
  localparam logic [CoreIdxW-1:0] ReservedCoreRst    = 3'd7;
  localparam logic [LoadW-1:0]    SaturationLevelRst = 8'd3;
  localparam logic [LoadW-1:0]    PackLimitRst       = 8'd2;

  typedef struct packed {
    logic                block_enable;
    logic [UtilW-1:0]    heavy_threshold;
    logic [UtilW-1:0]    light_threshold;
    logic                reserve_enable;
    logic [CoreIdxW-1:0] reserved_core;
    logic [LoadW-1:0]    saturation_level;
    logic                packing_on;
    logic [LoadW-1:0]    pack_limit;
  } cfg_t;

  // One placement request.
  typedef struct packed {
    logic [UtilW-1:0]     utilization;
    logic [CoreIdxW-1:0]  previous_core;
    logic [CoreCount-1:0] online_mask;
    logic [LoadW-1:0]     run_count_0;
    logic [LoadW-1:0]     run_count_1;
    logic [LoadW-1:0]     run_count_2;
    logic [LoadW-1:0]     run_count_3;
    logic [LoadW-1:0]     run_count_4;
    logic [LoadW-1:0]     run_count_5;
    logic [LoadW-1:0]     run_count_6;
    logic [LoadW-1:0]     run_count_7;
  } req_t;

  // One placement decision.
  typedef struct packed {
    logic [CoreIdxW-1:0] target_core;
    logic                use_default;
  } rsp_t;

  // Per-core findings handed from a lane to the merging stage.
  typedef struct packed {
    logic small_ok;    // online small core
    logic pack_ok;     // online small core under the packing limit
    logic big_cand;    // online big core that is not held in reserve
    logic unsat;       // candidate big core below saturation
    logic big_online;  // online big core
  } lane_t;

endpackage

`default_nettype wire

FILE: design/blcs_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module blcs_lane #(
  parameter int unsigned LANE        = 0,
  parameter int unsigned SMALL_CORES = blcs_pkg::SmallCoresDefault
) (
  input  blcs_pkg::cfg_t                 cfg_i,
  input  logic                           online_i,
  input  logic [blcs_pkg::LoadW-1:0]     load_i,
  output blcs_pkg::lane_t                lane_o
);
  import blcs_pkg::*;

  localparam logic                IsSmall = (LANE < SMALL_CORES);
  localparam logic [CoreIdxW-1:0] LaneIdx = CoreIdxW'(LANE);

  logic held_back;

  // A big core is held back when reservation is on and it is the reserved one.
  assign held_back = cfg_i.reserve_enable && (cfg_i.reserved_core == LaneIdx);

  // Classify this core for the merging stage.
  always_comb begin
    lane_o.small_ok   = IsSmall && online_i;
    lane_o.pack_ok    = IsSmall && online_i && (load_i < cfg_i.pack_limit);
    lane_o.big_online = !IsSmall && online_i;
    lane_o.big_cand   = !IsSmall && online_i && !held_back;
    lane_o.unsat      = lane_o.big_cand && (load_i < cfg_i.saturation_level);
  end

endmodule

`default_nettype wire

FILE: design/blcs_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module blcs_merge #(
  parameter int unsigned SMALL_CORES = blcs_pkg::SmallCoresDefault
) (
  input  blcs_pkg::cfg_t                   cfg_i,
  input  logic [blcs_pkg::UtilW-1:0]       util_i,
  input  logic [blcs_pkg::CoreIdxW-1:0]    prev_i,
  input  logic [blcs_pkg::CoreCount-1:0]   online_i,
  input  logic [blcs_pkg::LoadW-1:0]       load_i [blcs_pkg::CoreCount],
  input  blcs_pkg::lane_t                  lanes_i [blcs_pkg::CoreCount],
  output blcs_pkg::rsp_t                   rsp_o
);
  import blcs_pkg::*;

  localparam logic [CoreIdxW-1:0] SmallIdx = CoreIdxW'(SMALL_CORES);

  logic                 is_light;
  logic                 is_heavy;
  logic [CoreCount-1:0] scan_mask;
  logic                 min_found;
  logic [LoadW-1:0]     min_load;
  logic [CoreIdxW-1:0]  min_idx;
  logic                 pack_found;
  logic [CoreIdxW-1:0]  pack_idx;
  logic                 big_found;
  logic [CoreIdxW-1:0]  big_idx;
  logic                 all_sat;
  logic                 take_reserved;
  logic [CoreIdxW-1:0]  heavy_pick;
  logic [CoreIdxW-1:0]  heavy_idx;

  assign is_light = util_i < cfg_i.light_threshold;
  assign is_heavy = util_i >= cfg_i.heavy_threshold;

  // The lanes that compete on load depend on the task class.
  always_comb begin
    for (int i = 0; i < CoreCount; i++) begin
      scan_mask[i] = is_light ? lanes_i[i].small_ok : lanes_i[i].big_cand;
    end
  end

  // Least-loaded scan; a strict compare keeps the lowest index on ties.
  always_comb begin
    min_found = 1'b0;
    min_load  = '0;
    min_idx   = prev_i;
    for (int i = 0; i < CoreCount; i++) begin
      if (scan_mask[i] && (!min_found || load_i[i] < min_load)) begin
        min_found = 1'b1;
        min_load  = load_i[i];
        min_idx   = CoreIdxW'(i);
      end
    end
  end

  // First small core under the packing limit and first online big core.
  always_comb begin
    pack_found = 1'b0;
    pack_idx   = '0;
    big_found  = 1'b0;
    big_idx    = '0;
    for (int i = CoreCount - 1; i >= 0; i--) begin
      if (lanes_i[i].pack_ok) begin
        pack_found = 1'b1;
        pack_idx   = CoreIdxW'(i);
      end
      if (lanes_i[i].big_online) begin
        big_found = 1'b1;
        big_idx   = CoreIdxW'(i);
      end
    end
  end

  // The reserved core is used only when every candidate is saturated.
  always_comb begin
    all_sat = 1'b1;
    for (int i = 0; i < CoreCount; i++) begin
      if (lanes_i[i].unsat) begin
        all_sat = 1'b0;
      end
    end
    take_reserved = cfg_i.reserve_enable && all_sat &&
                    online_i[cfg_i.reserved_core] &&
                    (!min_found || load_i[cfg_i.reserved_core] < min_load);
    heavy_pick = take_reserved ? cfg_i.reserved_core : min_idx;
    heavy_idx  = (heavy_pick < SmallIdx && big_found) ? big_idx : heavy_pick;
  end

  // Final decision.
  always_comb begin
    rsp_o.use_default = 1'b1;
    rsp_o.target_core = '0;
    if (cfg_i.block_enable) begin
      if (is_light) begin
        rsp_o.use_default = 1'b0;
        rsp_o.target_core = (cfg_i.packing_on && pack_found) ? pack_idx : min_idx;
      end else if (is_heavy) begin
        rsp_o.use_default = 1'b0;
        rsp_o.target_core = heavy_idx;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/big_little_core_selector_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Big/little core selector.
// A placement request arrives on req_i with in_valid_i/in_ready_o and is
// taken at an edge where both are high. The decision leaves on rsp_o with
// out_valid_o/out_ready_i, in the cycle after the request was taken.
// Eight lanes, one per core, classify their core side by side; a merging
// stage finds the packing core, the least-loaded core and the reserve
// choice in the same cycle, and the result goes into the output register.
// Throughput is one request per cycle: a new request is taken while the
// output register is empty or is being emptied in the same cycle.
// When the receiver stalls, the result holds and in_ready_o falls until
// the result is taken.
// The configuration port writes one register per cycle at cfg_we_i; it
// should be written only while no request is in flight.
// Reset empties the output register and loads every configuration
// register with its default value.
module big_little_core_selector_core #(
  parameter int unsigned SMALL_CORES = blcs_pkg::SmallCoresDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  blcs_pkg::req_t                req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output blcs_pkg::rsp_t                rsp_o,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [blcs_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import blcs_pkg::*;

  cfg_t             cfg_q;
  logic [LoadW-1:0] loads [CoreCount];
  lane_t            lanes [CoreCount];
  rsp_t             rsp_d;
  rsp_t             rsp_q;
  logic             out_valid_q;
  logic             accept;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_enable     <= 1'b1;
      cfg_q.heavy_threshold  <= HeavyThresholdRst;
      cfg_q.light_threshold  <= LightThresholdRst;
      cfg_q.reserve_enable   <= 1'b1;
      cfg_q.reserved_core    <= ReservedCoreRst;
      cfg_q.saturation_level <= SaturationLevelRst;
      cfg_q.packing_on       <= 1'b1;
      cfg_q.pack_limit       <= PackLimitRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_BLOCK_ENABLE:     cfg_q.block_enable     <= cfg_wdata_i[0];
        REG_HEAVY_THRESHOLD:  cfg_q.heavy_threshold  <= cfg_wdata_i[UtilW-1:0];
        REG_LIGHT_THRESHOLD:  cfg_q.light_threshold  <= cfg_wdata_i[UtilW-1:0];
        REG_RESERVE_ENABLE:   cfg_q.reserve_enable   <= cfg_wdata_i[0];
        REG_RESERVED_CORE:    cfg_q.reserved_core    <= cfg_wdata_i[CoreIdxW-1:0];
        REG_SATURATION_LEVEL: cfg_q.saturation_level <= cfg_wdata_i[LoadW-1:0];
        REG_PACKING_ON:       cfg_q.packing_on       <= cfg_wdata_i[0];
        REG_PACK_LIMIT:       cfg_q.pack_limit       <= cfg_wdata_i[LoadW-1:0];
        default: ;
      endcase
    end
  end

  // Run counts laid out as one vector of lanes.
  assign loads[0] = req_i.run_count_0;
  assign loads[1] = req_i.run_count_1;
  assign loads[2] = req_i.run_count_2;
  assign loads[3] = req_i.run_count_3;
  assign loads[4] = req_i.run_count_4;
  assign loads[5] = req_i.run_count_5;
  assign loads[6] = req_i.run_count_6;
  assign loads[7] = req_i.run_count_7;

  // One lane per core.
  for (genvar g = 0; g < CoreCount; g++) begin : g_lane
    blcs_lane #(
      .LANE        (g),
      .SMALL_CORES (SMALL_CORES)
    ) u_lane (
      .cfg_i    (cfg_q),
      .online_i (req_i.online_mask[g]),
      .load_i   (loads[g]),
      .lane_o   (lanes[g])
    );
  end

  // Merge the lane findings into one decision.
  blcs_merge #(
    .SMALL_CORES (SMALL_CORES)
  ) u_merge (
    .cfg_i    (cfg_q),
    .util_i   (req_i.utilization),
    .prev_i   (req_i.previous_core),
    .online_i (req_i.online_mask),
    .load_i   (loads),
    .lanes_i  (lanes),
    .rsp_o    (rsp_d)
  );

  // Output register: refilled in the cycle it is emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

FILE: design/blcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module blcs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input blcs_pkg::rsp_t rsp_o
);
  import blcs_pkg::*;

  // No result may be offered in the cycle after reset is seen.
  `BLCS_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o)

  // A request taken always shows a result in the next cycle.
  `BLCS_ASSERT(a_request_fills, clk_i, rst_ni, in_valid_i && in_ready_o |=> out_valid_o)

  // An empty output stage must accept a request.
  `BLCS_ASSERT(a_empty_ready, clk_i, rst_ni, !out_valid_o |-> in_ready_o)

  // A deferred decision carries a zero target.
  `BLCS_ASSERT(a_default_zero, clk_i, rst_ni, out_valid_o && rsp_o.use_default |-> rsp_o.target_core == '0)

  // A stalled result holds.
  `BLCS_ASSERT(a_stall_holds, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(rsp_o))

endmodule

bind big_little_core_selector_core blcs_checker u_blcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .rsp_o       (rsp_o)
);

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import blcs_pkg::*;

  localparam int SmallCores     = SmallCoresDefault;
  localparam int CycleLimit     = 400000;
  localparam int RandomPerPhase = 193;
  localparam int PhaseCount     = 10;

  // Directed case: loads hold run_count_0 in the top byte, run_count_7 in the bottom.
  typedef struct packed {
    logic [UtilW-1:0]     util;
    logic [CoreIdxW-1:0]  prev;
    logic [CoreCount-1:0] mask;
    logic [63:0]          loads;
    logic                 typed;
    rsp_t                 want;
  } placement_case_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  req_t  req_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  rsp_t  rsp_o;
  logic  cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = REG_BLOCK_ENABLE;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  cfg_t active_cfg;
  rsp_t placement_q [$];
  int   decisions_checked = 0;
  int   deferred_seen = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  int   sender_burst = 0;
  int   receiver_burst = 0;
  bit   long_hold_pending = 1'b0;

  placement_case_t directed_cases [0:20] = '{
    '{11'd512,  3'd3, 8'hFF, 64'h00_00_00_00_00_00_00_00, 1'b1, '{3'd0, 1'b1}},
    '{11'd0,    3'd5, 8'hFF, 64'h00_00_00_00_00_00_00_00, 1'b1, '{3'd0, 1'b0}},
    '{11'd1024, 3'd0, 8'hFF, 64'h00_00_00_00_00_00_00_00, 1'b1, '{3'd4, 1'b0}},
    '{11'd255,  3'd6, 8'hFF, 64'h05_03_02_02_00_00_00_00, 1'b0, '0},
    '{11'd255,  3'd6, 8'hF0, 64'h00_00_00_00_00_00_00_00, 1'b0, '0},
    '{11'd256,  3'd1, 8'hFF, 64'h00_00_00_00_00_00_00_00, 1'b1, '{3'd0, 1'b1}},
    '{11'd699,  3'd1, 8'hFF, 64'h00_00_00_00_00_00_00_00, 1'b1, '{3'd0, 1'b1}},
    '{11'd700,  3'd1, 8'hFF, 64'h00_00_00_00_09_04_04_02, 1'b0, '0},
    '{11'd800,  3'd2, 8'hFF, 64'h00_00_00_00_03_05_04_06, 1'b0, '0},
    '{11'd1000, 3'd2, 8'h0F, 64'h01_01_01_01_01_01_01_01, 1'b0, '0},
    '{11'd1000, 3'd5, 8'h0F, 64'h01_01_01_01_01_01_01_01, 1'b0, '0},
    '{11'd1024, 3'd1, 8'h80, 64'hFF_FF_FF_FF_FF_FF_FF_FF, 1'b0, '0},
    '{11'd100,  3'd6, 8'h00, 64'h00_00_00_00_00_00_00_00, 1'b0, '0},
    '{11'd1000, 3'd3, 8'h00, 64'h00_00_00_00_00_00_00_00, 1'b0, '0},
    '{11'd10,   3'd0, 8'hFF, 64'hFF_FF_FF_FF_FF_FF_FF_FF, 1'b0, '0},
    '{11'd10,   3'd0, 8'hAA, 64'h03_03_01_00_00_00_00_00, 1'b0, '0},
    '{11'd900,  3'd0, 8'h55, 64'h00_00_00_00_02_00_01_00, 1'b0, '0},
    '{11'd900,  3'd0, 8'h70, 64'h00_00_00_00_07_07_07_00, 1'b0, '0},
    '{11'd1024, 3'd7, 8'h8F, 64'h00_00_00_00_00_00_00_00, 1'b0, '0},
    '{11'd0,    3'd0, 8'h00, 64'hAA_55_AA_55_AA_55_AA_55, 1'b0, '0},
    '{11'd1023, 3'd7, 8'h3C, 64'h55_AA_55_AA_55_AA_55_AA, 1'b0, '0}
  };

  // Register settings for the later phases, extremes first.
  cfg_t fixed_settings [0:6] = '{
    '{1'b1, 11'd0,    11'd0,    1'b1, 3'd4, 8'd0,   1'b1, 8'd0},
    '{1'b1, 11'd1024, 11'd1024, 1'b0, 3'd7, 8'd255, 1'b0, 8'd255},
    '{1'b1, 11'd0,    11'd1024, 1'b1, 3'd2, 8'd3,   1'b1, 8'd255},
    '{1'b0, 11'd700,  11'd256,  1'b1, 3'd7, 8'd3,   1'b1, 8'd2},
    '{1'b1, 11'd512,  11'd512,  1'b1, 3'd5, 8'd1,   1'b0, 8'd1},
    '{1'b1, 11'd1024, 11'd0,    1'b1, 3'd0, 8'd255, 1'b1, 8'd3},
    '{1'b1, 11'd700,  11'd256,  1'b1, 3'd7, 8'd3,   1'b1, 8'd2}
  };

  big_little_core_selector_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_i       (req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Works out the core that a placement request should land on.
  function automatic rsp_t predict_placement(input req_t r);
    logic [LoadW-1:0] load [CoreCount];
    rsp_t d;
    int   best;
    int   pick;
    bit   packed_in;
    bit   all_sat;
    {load[0], load[1], load[2], load[3], load[4], load[5], load[6], load[7]} =
      {r.run_count_0, r.run_count_1, r.run_count_2, r.run_count_3,
       r.run_count_4, r.run_count_5, r.run_count_6, r.run_count_7};
    d.target_core = '0;
    d.use_default = 1'b1;
    pick = int'(r.previous_core);
    best = 999;
    packed_in = 1'b0;
    all_sat = 1'b1;
    if (!active_cfg.block_enable) begin
      return d;
    end
    if (r.utilization < active_cfg.light_threshold) begin
      // Descending walk, so the lowest qualifying small core is kept.
      if (active_cfg.packing_on) begin
        for (int c = SmallCores - 1; c >= 0; c--) begin
          if (r.online_mask[c] && load[c] < active_cfg.pack_limit) begin
            pick = c;
            packed_in = 1'b1;
          end
        end
      end
      if (!packed_in) begin
        for (int c = 0; c < SmallCores; c++) begin
          if (r.online_mask[c] && load[c] < best) begin
            best = int'(load[c]);
            pick = c;
          end
        end
      end
    end else if (r.utilization >= active_cfg.heavy_threshold) begin
      for (int c = SmallCores; c < CoreCount; c++) begin
        if (r.online_mask[c] &&
            !(active_cfg.reserve_enable && c == active_cfg.reserved_core)) begin
          if (load[c] < active_cfg.saturation_level) all_sat = 1'b0;
          if (load[c] < best) begin
            best = int'(load[c]);
            pick = c;
          end
        end
      end
      // The reserved core only steps in when every other big core is saturated.
      if (active_cfg.reserve_enable && all_sat && r.online_mask[active_cfg.reserved_core] &&
          load[active_cfg.reserved_core] < best) begin
        pick = int'(active_cfg.reserved_core);
      end
      if (pick < SmallCores) begin
        for (int c = CoreCount - 1; c >= SmallCores; c--) begin
          if (r.online_mask[c]) pick = c;
        end
      end
    end else begin
      return d;
    end
    d.target_core = CoreIdxW'(pick);
    d.use_default = 1'b0;
    return d;
  endfunction

  // Random request, leaning on the thresholds and limits now in force.
  function automatic req_t random_request();
    logic [LoadW-1:0]     load [CoreCount];
    logic [CoreCount-1:0] mask;
    int lt;
    int ht;
    int u;
    int v;
    lt = int'(active_cfg.light_threshold);
    ht = int'(active_cfg.heavy_threshold);
    case ($urandom_range(0, 9))
      0, 1, 2: u = (lt > 0) ? int'($urandom_range(0, lt - 1)) : int'($urandom_range(0, 1024));
      3, 4, 5: u = (ht <= 1024) ? int'($urandom_range(ht, 1024)) : int'($urandom_range(0, 1024));
      7: begin
        case ($urandom_range(0, 3))
          0: u = lt - 1;
          1: u = lt;
          2: u = ht - 1;
          default: u = ht;
        endcase
      end
      8: u = $urandom_range(0, 1) ? 1024 : 0;
      default: u = $urandom_range(0, 1024);
    endcase
    if (u < 0) u = 0;
    if (u > 1024) u = 1024;
    case ($urandom_range(0, 9))
      0, 1: mask = 8'hFF;
      2: mask = 8'h0F;
      3: mask = 8'hF0;
      4: mask = 8'h00;
      5: mask = 8'h01 << $urandom_range(0, 7);
      default: mask = CoreCount'($urandom);
    endcase
    for (int c = 0; c < CoreCount; c++) begin
      case ($urandom_range(0, 7))
        4: v = int'(active_cfg.saturation_level) + int'($urandom_range(0, 2)) - 1;
        5: v = int'(active_cfg.pack_limit) + int'($urandom_range(0, 2)) - 1;
        6: v = $urandom_range(0, 255);
        7: v = $urandom_range(0, 1) ? 255 : 0;
        default: v = $urandom_range(0, 5);
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      load[c] = LoadW'(v);
    end
    return {UtilW'(u), CoreIdxW'($urandom_range(0, 7)), mask,
            load[0], load[1], load[2], load[3], load[4], load[5], load[6], load[7]};
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    s.block_enable     = ($urandom_range(0, 7) != 0);
    s.heavy_threshold  = UtilW'($urandom_range(0, 1024));
    s.light_threshold  = UtilW'($urandom_range(0, 1024));
    s.reserve_enable   = 1'($urandom_range(0, 1));
    s.reserved_core    = CoreIdxW'($urandom_range(0, 7));
    s.saturation_level = LoadW'($urandom_range(0, 255));
    s.packing_on       = 1'($urandom_range(0, 1));
    s.pack_limit       = LoadW'($urandom_range(0, 255));
    return s;
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // Narrow registers get random upper bits, which the block must drop.
  task automatic apply_settings(input cfg_t s);
    write_reg(REG_BLOCK_ENABLE, {10'($urandom), s.block_enable});
    write_reg(REG_HEAVY_THRESHOLD, s.heavy_threshold);
    write_reg(REG_LIGHT_THRESHOLD, s.light_threshold);
    write_reg(REG_RESERVE_ENABLE, {10'($urandom), s.reserve_enable});
    write_reg(REG_RESERVED_CORE, {8'($urandom), s.reserved_core});
    write_reg(REG_SATURATION_LEVEL, {3'($urandom), s.saturation_level});
    write_reg(REG_PACKING_ON, {10'($urandom), s.packing_on});
    write_reg(REG_PACK_LIMIT, {3'($urandom), s.pack_limit});
    cfg_we_i <= 1'b0;
    active_cfg = s;
  endtask

  // Offers one request after a random gap and records its expected decision once taken.
  task automatic send_request(input req_t r, input logic typed, input rsp_t want);
    int gap;
    if (sender_burst > 0) begin
      gap = 0;
      sender_burst--;
    end else if ($urandom_range(0, 24) == 0) begin
      gap = 0;
      sender_burst = $urandom_range(10, 40);
    end else begin
      gap = $urandom_range(0, 15);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_i      <= r;
    do @(posedge clk_i); while (!in_ready_o);
    placement_q.push_back(typed ? want : predict_placement(r));
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls per decision, bursts without stalls, and one long hold on demand.
  initial begin : receiver
    int stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold_pending) begin
        stall = 80;
        long_hold_pending = 1'b0;
      end else if (receiver_burst > 0) begin
        stall = 0;
        receiver_burst--;
      end else if ($urandom_range(0, 24) == 0) begin
        stall = 0;
        receiver_burst = $urandom_range(10, 40);
      end else begin
        stall = $urandom_range(0, 15);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Decision checker against the oldest outstanding expectation.
  always @(posedge clk_i) begin : check_decisions
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (placement_q.size() == 0) begin
        $display("%0t: unexpected decision, expected none, actual %p", $time, rsp_o);
        mismatches++;
      end else begin
        want = placement_q.pop_front();
        decisions_checked++;
        if (want.use_default) deferred_seen++;
        if (rsp_o.use_default !== want.use_default) begin
          $display("%0t: use_default mismatch, expected %0d, actual %0d",
                   $time, want.use_default, rsp_o.use_default);
          mismatches++;
        end
        if (rsp_o.target_core !== want.target_core) begin
          $display("%0t: target_core mismatch, expected %0d, actual %0d",
                   $time, want.target_core, rsp_o.target_core);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run timed out", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Main sequence: directed cases under reset values, then random phases per setting.
  initial begin : stimulus
    placement_case_t row;
    active_cfg = '{1'b1, HeavyThresholdRst, LightThresholdRst, 1'b1, ReservedCoreRst,
                   SaturationLevelRst, 1'b1, PackLimitRst};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_cases[i]) begin
      row = directed_cases[i];
      send_request({row.util, row.prev, row.mask, row.loads}, row.typed, row.want);
    end

    for (int p = 0; p < PhaseCount; p++) begin
      if (p > 0) begin
        drain_requests();
        repeat (2) @(posedge clk_i);
        apply_settings((p <= 7) ? fixed_settings[p - 1] : random_settings());
      end
      // Stall the receiver for a long stretch while requests keep coming back to back.
      if (p == 1 || p == 6) begin
        long_hold_pending = 1'b1;
        sender_burst = 40;
      end
      for (int i = 0; i < RandomPerPhase; i++) begin
        if (p % 2 == 1 && i == RandomPerPhase / 2) drain_requests();
        send_request(random_request(), 1'b0, '0);
      end
    end

    drain_requests();
    repeat (4) @(posedge clk_i);
    $display("Checked %0d placement decisions (%0d deferred) across %0d register settings,",
             decisions_checked, deferred_seen, PhaseCount);
    $display("with directed corner cases, random stalls on both sides and long back-pressure.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/blcs_pkg.sv
design/blcs_lane.sv
design/blcs_merge.sv
design/big_little_core_selector_core.sv
design/blcs_checker.sv
verif/testbench.sv
